// ----- hw/rtl/multi_tap_name_entry_defines.svh -----
// ----------------------------------------------------------------------------
// multi_tap_name_entry_defines.svh
// Assertion macros for the multi-tap name entry block.
// ----------------------------------------------------------------------------
`ifndef MULTI_TAP_NAME_ENTRY_DEFINES_SVH
`define MULTI_TAP_NAME_ENTRY_DEFINES_SVH

// Concurrent check, disabled while reset is high.
`define MTNE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs during reset.
`define MTNE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/mtne_pkg.sv -----
// ----------------------------------------------------------------------------
// mtne_pkg
// Shared constants, codes and letter tables for the multi-tap name entry.
// ----------------------------------------------------------------------------
package mtne_pkg;

   localparam int NAME_MAX = 16;
   localparam int LEN_W    = $clog2(NAME_MAX + 1);
   localparam int POS_W    = $clog2(NAME_MAX);

   localparam logic [15:0] TAP_WINDOW_RESET = 16'd800;

   // csr register index (paddr[2])
   localparam logic CSR_IDX_TAP_WINDOW = 1'b0;

   // func codes
   localparam logic [2:0] FUNC_PRESS   = 3'd0;
   localparam logic [2:0] FUNC_TICK    = 3'd1;
   localparam logic [2:0] FUNC_BACK    = 3'd2;
   localparam logic [2:0] FUNC_APPEND  = 3'd3;
   localparam logic [2:0] FUNC_CLEAR   = 3'd4;
   localparam logic [2:0] FUNC_RESTART = 3'd5;

   // key codes
   localparam logic [3:0] KEY_LETTER_LO = 4'd1;
   localparam logic [3:0] KEY_LETTER_HI = 4'd8;
   localparam logic [3:0] KEY_DEL       = 4'd9;
   localparam logic [3:0] KEY_SPACE     = 4'd10;
   localparam logic [3:0] KEY_OK        = 4'd11;

   // result kinds
   localparam logic [1:0] KIND_STATUS      = 2'd0;
   localparam logic [1:0] KIND_SAVED_CHAR  = 2'd1;
   localparam logic [1:0] KIND_SAVED_EMPTY = 2'd2;
   localparam logic [1:0] KIND_LEFT        = 2'd3;

   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic             done_res;
      logic [3:0]       pending_key;
      logic             letter_pending;
      logic [LEN_W-1:0] name_length;
      logic [7:0]       char_out;
      logic [POS_W-1:0] char_pos;
      logic             char_written;
   } rsp_fields_type;

   function automatic logic [7:0] letter_base(input logic [3:0] key);
      logic [7:0] base;
      case (key)
         4'd1:    base = 8'h41; // A
         4'd2:    base = 8'h44; // D
         4'd3:    base = 8'h47; // G
         4'd4:    base = 8'h4A; // J
         4'd5:    base = 8'h4D; // M
         4'd6:    base = 8'h50; // P
         4'd7:    base = 8'h54; // T
         4'd8:    base = 8'h57; // W
         default: base = 8'h00;
      endcase
      return base;
   endfunction

   function automatic logic [2:0] letter_count(input logic [3:0] key);
      logic [2:0] cnt;
      case (key)
         4'd6, 4'd8: cnt = 3'd4;
         default:    cnt = 3'd3;
      endcase
      return cnt;
   endfunction

endpackage

// ----- hw/rtl/multi_tap_name_entry.sv -----
// ----------------------------------------------------------------------------
// multi_tap_name_entry
// Multi-tap name entry on a 12-key pad; name kept in a 16 x 8 RAM.
// Flow: an input is taken only in ST_IDLE; ST_EXEC then registers its result,
//   waiting while the output is stalled. A save alternates ST_READ and ST_STREAM
//   (a RAM read state, then an output state, for each stored character). A new
//   input is taken only back in ST_IDLE, once the last result is registered.
// Reset: synchronous, active high; clears control state, tap_window to 800.
//   The name RAM is not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module multi_tap_name_entry (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: key[3:0], char_in[11:4], now[43:12], zero[47:44]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // req_tuser: func[2:0]
   input  logic [2:0]  req_tuser,
   // rsp_tdata: char_written[0], char_pos[4:1], char_out[12:5],
   //   name_length[17:13], letter_pending[18], pending_key[22:19], done_res[23]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // rsp_tuser: kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import mtne_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_STREAM = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [2:0]       func_ff;
   logic [3:0]       key_ff;
   logic [7:0]       char_ff;
   logic [31:0]      now_ff;
   logic [LEN_W-1:0] name_len_ff, name_len_in;
   logic             live_valid_ff, live_valid_in;
   logic [3:0]       live_key_ff, live_key_in;
   logic [1:0]       tap_index_ff, tap_index_in;
   logic [31:0]      tap_time_ff, tap_time_in;
   logic             done_ff, done_in;
   logic [15:0]      tap_window_ff;
   logic [POS_W-1:0] rd_pos_ff, rd_pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff;
   rsp_fields_type   rsp_data_ff;
   logic             rsp_last_ff;

   logic             req_fire;
   logic             slot_free;
   logic             emit;
   logic [1:0]       res_kind;
   logic             res_last;
   rsp_fields_type   res;
   logic             wr_en;
   logic [POS_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [7:0]       rd_data;
   logic [31:0]      elapsed;
   logic             in_window;
   logic [LEN_W-1:0] len_m1;
   logic [LEN_W-1:0] rd_pos_p1;
   logic [2:0]       tap_cnt;
   logic [2:0]       tap_p1;
   logic [1:0]       tap_next;
   logic [7:0]       letter_first;
   logic [7:0]       letter_cycled;
   logic             csr_wr;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == CSR_IDX_TAP_WINDOW);
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_TAP_WINDOW) ? {16'd0, tap_window_ff} : 32'd0;

   assign elapsed       = now_ff - tap_time_ff;
   assign in_window     = elapsed < {16'd0, tap_window_ff};
   assign len_m1        = name_len_ff - LEN_W'(1);
   assign rd_pos_p1     = {1'b0, rd_pos_ff} + LEN_W'(1);
   assign tap_cnt       = letter_count(key_ff);
   assign tap_p1        = {1'b0, tap_index_ff} + 3'd1;
   assign tap_next      = (tap_p1 == tap_cnt) ? 2'd0 : tap_p1[1:0];
   assign letter_first  = letter_base(key_ff);
   assign letter_cycled = letter_first + {6'd0, tap_next};

   always_comb begin
      state_in      = state_ff;
      name_len_in   = name_len_ff;
      live_valid_in = live_valid_ff;
      live_key_in   = live_key_ff;
      tap_index_in  = tap_index_ff;
      tap_time_in   = tap_time_ff;
      done_in       = done_ff;
      rd_pos_in     = rd_pos_ff;
      wr_en         = 1'b0;
      wr_addr       = name_len_ff[POS_W-1:0];
      wr_data       = 8'd0;
      emit          = 1'b0;
      res_kind      = KIND_STATUS;
      res_last      = 1'b1;
      res           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               unique case (func_ff)
                  FUNC_PRESS: begin
                     case (key_ff) inside
                        KEY_OK: begin
                           live_valid_in = 1'b0;
                           live_key_in   = 4'd0;
                           tap_index_in  = 2'd0;
                           done_in       = 1'b1;
                           if (name_len_ff == '0) begin
                              res_kind = KIND_SAVED_EMPTY;
                           end else begin
                              emit      = 1'b0;
                              rd_pos_in = '0;
                              state_in  = ST_READ;
                           end
                        end
                        KEY_DEL: begin
                           live_valid_in = 1'b0;
                           live_key_in   = 4'd0;
                           tap_index_in  = 2'd0;
                           if (name_len_ff != '0) begin
                              name_len_in = len_m1;
                           end
                        end
                        KEY_SPACE: begin
                           live_valid_in = 1'b0;
                           live_key_in   = 4'd0;
                           tap_index_in  = 2'd0;
                           if (name_len_ff < LEN_W'(NAME_MAX)) begin
                              wr_en            = 1'b1;
                              wr_data          = CHAR_SPACE;
                              name_len_in      = name_len_ff + LEN_W'(1);
                              res.char_written = 1'b1;
                              res.char_pos     = name_len_ff[POS_W-1:0];
                              res.char_out     = CHAR_SPACE;
                           end
                        end
                        [KEY_LETTER_LO:KEY_LETTER_HI]: begin
                           if (live_valid_ff && (live_key_ff == key_ff) && in_window &&
                               (name_len_ff != '0)) begin
                              tap_index_in     = tap_next;
                              tap_time_in      = now_ff;
                              wr_en            = 1'b1;
                              wr_addr          = len_m1[POS_W-1:0];
                              wr_data          = letter_cycled;
                              res.char_written = 1'b1;
                              res.char_pos     = len_m1[POS_W-1:0];
                              res.char_out     = letter_cycled;
                           end else if (name_len_ff < LEN_W'(NAME_MAX)) begin
                              tap_index_in     = 2'd0;
                              live_key_in      = key_ff;
                              live_valid_in    = 1'b1;
                              tap_time_in      = now_ff;
                              wr_en            = 1'b1;
                              wr_data          = letter_first;
                              name_len_in      = name_len_ff + LEN_W'(1);
                              res.char_written = 1'b1;
                              res.char_pos     = name_len_ff[POS_W-1:0];
                              res.char_out     = letter_first;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
                  FUNC_TICK: begin
                     if (live_valid_ff && !in_window) begin
                        live_valid_in = 1'b0;
                        live_key_in   = 4'd0;
                        tap_index_in  = 2'd0;
                     end
                  end
                  FUNC_BACK: begin
                     live_valid_in = 1'b0;
                     live_key_in   = 4'd0;
                     tap_index_in  = 2'd0;
                     done_in       = 1'b1;
                     res_kind      = KIND_LEFT;
                  end
                  FUNC_APPEND: begin
                     live_valid_in = 1'b0;
                     live_key_in   = 4'd0;
                     tap_index_in  = 2'd0;
                     if (name_len_ff < LEN_W'(NAME_MAX)) begin
                        wr_en            = 1'b1;
                        wr_data          = char_ff;
                        name_len_in      = name_len_ff + LEN_W'(1);
                        res.char_written = 1'b1;
                        res.char_pos     = name_len_ff[POS_W-1:0];
                        res.char_out     = char_ff;
                     end
                  end
                  FUNC_CLEAR: begin
                     live_valid_in = 1'b0;
                     live_key_in   = 4'd0;
                     tap_index_in  = 2'd0;
                     name_len_in   = '0;
                  end
                  FUNC_RESTART: begin
                     live_valid_in = 1'b0;
                     live_key_in   = 4'd0;
                     tap_index_in  = 2'd0;
                     name_len_in   = '0;
                     done_in       = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_STREAM;
         end
         ST_STREAM: begin
            if (slot_free) begin
               emit             = 1'b1;
               res_kind         = KIND_SAVED_CHAR;
               res.char_written = 1'b1;
               res.char_pos     = rd_pos_ff;
               res.char_out     = rd_data;
               res_last         = (rd_pos_p1 == name_len_ff);
               rd_pos_in        = rd_pos_p1[POS_W-1:0];
               state_in         = res_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      res.name_length    = name_len_in;
      res.letter_pending = live_valid_in;
      res.pending_key    = live_valid_in ? live_key_in : 4'd0;
      res.done_res       = done_in;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         name_len_ff   <= '0;
         live_valid_ff <= 1'b0;
         live_key_ff   <= 4'd0;
         tap_index_ff  <= 2'd0;
         tap_time_ff   <= 32'd0;
         done_ff       <= 1'b0;
         tap_window_ff <= TAP_WINDOW_RESET;
         rd_pos_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         name_len_ff   <= name_len_in;
         live_valid_ff <= live_valid_in;
         live_key_ff   <= live_key_in;
         tap_index_ff  <= tap_index_in;
         tap_time_ff   <= tap_time_in;
         done_ff       <= done_in;
         rd_pos_ff     <= rd_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr) begin
            tap_window_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff <= req_tuser;
         key_ff  <= req_tdata[3:0];
         char_ff <= req_tdata[11:4];
         now_ff  <= req_tdata[43:12];
      end
      if (emit) begin
         rsp_kind_ff <= res_kind;
         rsp_data_ff <= res;
         rsp_last_ff <= res_last;
      end
   end

   mtne_ram #(
      .WIDTH (8),
      .DEPTH (NAME_MAX)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_pos_ff),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- hw/rtl/mtne_ram.sv -----
// ----------------------------------------------------------------------------
// mtne_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtne_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/mtne_checker.sv -----
// ----------------------------------------------------------------------------
// mtne_checker
// Port-level checks for the multi-tap name entry, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_tap_name_entry_defines.svh"

module mtne_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   import mtne_pkg::*;

   `MTNE_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

   `MTNE_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled rsp transaction changed")

   `MTNE_ASSERT(a_saved_char_done, clock, reset, rsp_tvalid && (rsp_tuser == KIND_SAVED_CHAR) |-> rsp_tdata[0] && rsp_tdata[23] && !rsp_tdata[18], "saved character without done or with pending letter")

   `MTNE_ASSERT(a_single_result_last, clock, reset, rsp_tvalid && (rsp_tuser == KIND_STATUS || rsp_tuser == KIND_LEFT || rsp_tuser == KIND_SAVED_EMPTY) |-> rsp_tlast, "single-result transaction not marked last")

   `MTNE_ASSERT(a_pending_key_zero, clock, reset, rsp_tvalid && !rsp_tdata[18] |-> rsp_tdata[22:19] == 4'd0, "pending key set without pending letter")

endmodule

bind multi_tap_name_entry mtne_checker u_mtne_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- bench/multi_tap_name_entry_test.sv -----
// ----------------------------------------------------------------------------
// multi_tap_name_entry_test
// Self-checking bench for the multi-tap name entry block. Key presses,
// ticks and edit commands are streamed in with random gaps, and every
// result transaction is checked against a transaction-level model of the
// name buffer and the pending letter. The tap window is rewritten between
// phases, the extremes among them.
// ----------------------------------------------------------------------------
module multi_tap_name_entry_test;
   import mtne_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;
   localparam logic [3:0] KEY_NONE     = 4'd0;
   localparam logic [3:0] KEY_SPARE    = 4'd15;
   localparam logic [2:0] TAP_WINDOW_ADDR = {CSR_IDX_TAP_WINDOW, 2'b00};
   localparam int SHOWN_MAX = 10;

   typedef struct packed {
      logic [1:0]     kind;
      rsp_fields_type fields;
      logic           last;
   } name_result_type;

   class name_board;
      name_result_type expected_results[$];
      logic [7:0]   name_chars[NAME_MAX];
      int           char_count;
      bit           letter_live;
      logic [3:0]   held_key;
      int           tap_step;
      logic [31:0]  last_tap;
      bit           entry_done;
      logic [15:0]  window;
      string        letter_sets[9];
      int           fail_count;

      function new();
         letter_sets = '{"", "ABC", "DEF", "GHI", "JKL", "MNO", "PQRS", "TUV", "WXYZ"};
         char_count = 0;
         letter_live = 0;
         held_key = KEY_NONE;
         tap_step = 0;
         last_tap = '0;
         entry_done = 0;
         window = TAP_WINDOW_RESET;
         fail_count = 0;
      endfunction

      function void release_letter();
         letter_live = 0;
         held_key = KEY_NONE;
         tap_step = 0;
      endfunction

      function void push(logic [1:0] kind, logic wrote, int pos, logic [7:0] ch,
                         logic last);
         name_result_type r;
         r.kind = kind;
         r.fields.char_written = wrote;
         r.fields.char_pos = pos[POS_W-1:0];
         r.fields.char_out = ch;
         r.fields.name_length = char_count[LEN_W-1:0];
         r.fields.letter_pending = letter_live;
         r.fields.pending_key = letter_live ? held_key : KEY_NONE;
         r.fields.done_res = entry_done;
         r.last = last;
         expected_results.push_back(r);
      endfunction

      function void note_input(logic [2:0] func, logic [3:0] key, logic [7:0] cin,
                               logic [31:0] now);
         logic        wrote;
         int          pos;
         logic [7:0]  ch;
         logic [31:0] elapsed;
         int          cnt;
         int          n;
         wrote = 0;
         pos = 0;
         ch = '0;
         elapsed = now - last_tap;
         case (func)
            FUNC_PRESS: begin
               if (key == KEY_OK) begin
                  release_letter();
                  entry_done = 1;
                  if (char_count == 0) begin
                     push(KIND_SAVED_EMPTY, 0, 0, '0, 1);
                  end else begin
                     n = (char_count < NAME_MAX) ? char_count : NAME_MAX;
                     for (int i = 0; i < n; i++)
                        push(KIND_SAVED_CHAR, 1, i, name_chars[i], i == n - 1);
                  end
                  return;
               end else if (key == KEY_DEL) begin
                  release_letter();
                  if (char_count > 0) char_count--;
               end else if (key == KEY_SPACE) begin
                  release_letter();
                  if (char_count < NAME_MAX) begin
                     name_chars[char_count] = CHAR_SPACE;
                     char_count++;
                     wrote = 1; pos = char_count - 1; ch = CHAR_SPACE;
                  end
               end else if (key >= KEY_LETTER_LO && key <= KEY_LETTER_HI) begin
                  cnt = letter_sets[key].len();
                  if (letter_live && held_key == key && elapsed < {16'h0, window} &&
                      char_count > 0) begin
                     tap_step = (tap_step + 1) % cnt;
                     name_chars[char_count-1] = letter_sets[key][tap_step];
                     wrote = 1; pos = char_count - 1; ch = name_chars[char_count-1];
                     last_tap = now;
                  end else if (char_count < NAME_MAX) begin
                     tap_step = 0;
                     name_chars[char_count] = letter_sets[key][0];
                     char_count++;
                     held_key = key;
                     letter_live = 1;
                     wrote = 1; pos = char_count - 1; ch = name_chars[char_count-1];
                     last_tap = now;
                  end
               end
            end
            FUNC_TICK: begin
               if (letter_live && elapsed >= {16'h0, window}) release_letter();
            end
            FUNC_BACK: begin
               release_letter();
               entry_done = 1;
               push(KIND_LEFT, 0, 0, '0, 1);
               return;
            end
            FUNC_APPEND: begin
               release_letter();
               if (char_count < NAME_MAX) begin
                  name_chars[char_count] = cin;
                  char_count++;
                  wrote = 1; pos = char_count - 1; ch = cin;
               end
            end
            FUNC_CLEAR: begin
               release_letter();
               char_count = 0;
            end
            FUNC_RESTART: begin
               char_count = 0;
               release_letter();
               entry_done = 0;
            end
            default: ;
         endcase
         push(KIND_STATUS, wrote, pos, ch, 1);
      endfunction

      function void check_result(name_result_type got);
         name_result_type want;
         bit              bad;
         string           want_text;
         string           got_text;
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOWN_MAX)
               $display("unexpected result: kind=%0d data=%h last=%0d",
                        got.kind, got.fields, got.last);
            return;
         end
         want = expected_results.pop_front();
         bad = (got.kind !== want.kind) ||
               (got.fields.char_written !== want.fields.char_written) ||
               (got.fields.char_pos !== want.fields.char_pos) ||
               (got.fields.char_out !== want.fields.char_out) ||
               (got.fields.name_length !== want.fields.name_length) ||
               (got.fields.letter_pending !== want.fields.letter_pending) ||
               (got.fields.pending_key !== want.fields.pending_key) ||
               (got.fields.done_res !== want.fields.done_res) ||
               (got.last !== want.last);
         if (bad) begin
            fail_count++;
            if (fail_count <= SHOWN_MAX) begin
               want_text = $sformatf(
                  "kind=%0d wr=%0d pos=%0d ch=%h len=%0d pend=%0d key=%0d done=%0d last=%0d",
                  want.kind, want.fields.char_written, want.fields.char_pos,
                  want.fields.char_out, want.fields.name_length,
                  want.fields.letter_pending, want.fields.pending_key,
                  want.fields.done_res, want.last);
               got_text = $sformatf(
                  "kind=%0d wr=%0d pos=%0d ch=%h len=%0d pend=%0d key=%0d done=%0d last=%0d",
                  got.kind, got.fields.char_written, got.fields.char_pos,
                  got.fields.char_out, got.fields.name_length,
                  got.fields.letter_pending, got.fields.pending_key,
                  got.fields.done_res, got.last);
               $display("mismatch: expected %s, got %s", want_text, got_text);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   name_board   board = new();
   int          items_sent;
   bit          calm;
   logic [31:0] stamp;

   multi_tap_name_entry uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stall bursts
   initial begin : rsp_side
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 4);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result({rsp_tuser, rsp_fields_type'(rsp_tdata), rsp_tlast});
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_req(input logic [2:0] func, input logic [3:0] key,
                           input logic [7:0] cin, input logic [31:0] now);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {4'h0, now, cin, key};
      do @(posedge clock); while (!req_tready);
      board.note_input(func, key, cin, now);
      items_sent++;
   endtask

   task automatic press(input logic [3:0] key, input logic [31:0] now);
      send_req(FUNC_PRESS, key, 8'h00, now);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [15:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TAP_WINDOW_ADDR;
      csr_pwdata  <= {16'h0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.window = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [31:0] short_gap();
      return (board.window > 1) ? $urandom_range(0, board.window - 1) : 32'd0;
   endfunction

   function automatic logic [31:0] long_gap();
      return {16'h0, board.window} + $urandom_range(0, 1000);
   endfunction

   task automatic noise_item();
      logic [31:0] t;
      t = ($urandom_range(0, 1) == 0) ? $urandom() : stamp;
      send_req(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
               8'($urandom()), t);
   endtask

   // one name entry with occasional noise items, usually ended by save, back or clear
   task automatic type_name(input int min_len);
      int         length;
      int         reps;
      int         r;
      logic [3:0] k;
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 6);
      if (length < min_len) length = min_len;
      for (int i = 0; i < length; i++) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            k = 4'($urandom_range(KEY_LETTER_LO, KEY_LETTER_HI));
            if ($urandom_range(0, 9) == 0) stamp = $urandom();
            else stamp = stamp + long_gap();
            press(k, stamp);
            reps = $urandom_range(0, 4);
            repeat (reps) begin
               stamp = stamp + short_gap();
               press(k, stamp);
            end
            r = $urandom_range(0, 2);
            if (r == 0) send_req(FUNC_TICK, KEY_NONE, 8'h00, stamp + short_gap());
            else if (r == 1) begin
               stamp = stamp + long_gap();
               send_req(FUNC_TICK, KEY_NONE, 8'h00, stamp);
            end
         end else if (r == 6) press(KEY_SPACE, stamp);
         else if (r == 7) press(KEY_DEL, stamp);
         else if (r == 8) send_req(FUNC_APPEND, KEY_NONE, 8'($urandom()), stamp);
         else noise_item();
      end
      r = $urandom_range(0, 9);
      if (r < 7) press(KEY_OK, stamp);
      else if (r == 7) send_req(FUNC_BACK, KEY_NONE, 8'h00, stamp);
      else if (r == 8) send_req(FUNC_CLEAR, KEY_NONE, 8'h00, stamp);
      if ($urandom_range(0, 1) == 0) send_req(FUNC_RESTART, KEY_NONE, 8'h00, stamp);
      if ($urandom_range(0, 5) == 0) drain();
   endtask

   task automatic random_phase(input int target);
      while (items_sent < target) begin
         if ($urandom_range(0, 4) == 0) noise_item();
         else type_name(0);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = FUNC_PRESS;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      items_sent  = 0;
      calm        = 0;
      stamp       = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // directed part, window at its reset value
      press(KEY_OK, 32'h0);                       // save with the name empty
      send_req(FUNC_RESTART, KEY_NONE, 8'h00, 32'h0);
      press(4'd1, 32'hFFFF_FFF0);
      press(4'd1, 32'h0000_0010);                 // cycles across the wrap
      press(4'd1, 32'h0000_0020);
      press(4'd1, 32'h0000_0030);
      send_req(FUNC_TICK, KEY_NONE, 8'h00, 32'h0000_0040);
      press(KEY_NONE, 32'h0000_0050);
      press(KEY_SPARE, 32'h0000_0058);
      press(4'd1, 32'h0000_0060);
      send_req(FUNC_TICK, KEY_NONE, 8'h00, 32'h0000_0060 + 32'd800);
      for (int i = 0; i < 5; i++) press(4'd8, 32'h0000_1000 + i);
      press(4'd8, 32'h0000_2000);
      press(KEY_SPACE, 32'h0000_2001);
      press(KEY_DEL, 32'h0000_2002);
      send_req(FUNC_APPEND, KEY_NONE, 8'hFF, 32'h0000_2003);
      send_req(FUNC_APPEND, KEY_NONE, 8'h00, 32'h0000_2004);
      send_req(FUNC_SPARE_A, KEY_OK, 8'hAA, 32'h0000_2005);
      send_req(FUNC_SPARE_B, KEY_DEL, 8'h55, 32'h0000_2006);
      send_req(FUNC_BACK, KEY_NONE, 8'h00, 32'h0000_2007);
      press(4'd2, 32'h0000_2008);                 // still handled after done
      send_req(FUNC_CLEAR, KEY_NONE, 8'h00, 32'h0000_2009);
      press(KEY_DEL, 32'h0000_200A);
      send_req(FUNC_RESTART, KEY_NONE, 8'h00, 32'h0000_200B);
      stamp = 32'h0001_0000;

      drain();
      csr_write(16'hFFFF);
      type_name(18);                              // at least 18 entry steps, which may overfill the name
      random_phase(90);

      drain();
      csr_write(16'd1);
      random_phase(140);

      drain();
      csr_write(16'd0);
      random_phase(160);

      drain();
      csr_write(16'($urandom_range(2, 2000)));
      random_phase(195);

      drain();
      calm = 1;
      csr_write(TAP_WINDOW_RESET);
      random_phase(235);

      drain();
      repeat (20) @(posedge clock);
      if (board.expected_results.size() != 0)
         $display("%0d expected results never arrived", board.expected_results.size());
      if (board.fail_count == 0 && board.expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- multi_tap_name_entry.f -----
+incdir+hw/rtl
hw/rtl/mtne_pkg.sv
hw/rtl/mtne_ram.sv
hw/rtl/multi_tap_name_entry.sv
hw/rtl/mtne_checker.sv
bench/multi_tap_name_entry_test.sv
